// ----- hdl/cdmf_pkg.sv -----
`default_nettype none

package cdmf_pkg;

    // Field widths of one received message key
    localparam int unsigned ADDR_W  = 32;
    localparam int unsigned PORT_W  = 16;
    localparam int unsigned MID_W   = 16;
    localparam int unsigned TIME_W  = 32;

    // Lifetime register value after reset, in milliseconds
    localparam logic [TIME_W-1:0] LIFETIME_RESET = 32'd247000;

    // One stored table entry: message key plus arrival stamp
    typedef struct packed {
        logic [ADDR_W-1:0] address;
        logic [PORT_W-1:0] port;
        logic [MID_W-1:0]  msg_id;
        logic [TIME_W-1:0] stamp;
    } entry_t;

    // Controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_INSERT
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic load;     // capture the key and start reading entry 0
        logic scan;     // evaluate the current entry and step to the next
        logic insert;   // store the key at the insert pointer
        logic respond;  // present a result next cycle
        logic dup;      // result value to present
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic live_hit;     // current entry matches and is still live
        logic last_entry;   // current entry is the last one of the table
    } sts_t;

endpackage

`default_nettype wire

// ----- hdl/cdmf_ctrl.sv -----
`default_nettype none

module cdmf_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  cdmf_pkg::sts_t     sts,
    output cdmf_pkg::cmd_t     cmd,
    output logic               busy
);
    import cdmf_pkg::*;

    state_t state_reg;
    state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.live_hit)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.last_entry)
                begin
                    state_next = ST_INSERT;
                end
            end
            ST_INSERT:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs: datapath commands and busy
    always_comb
    begin
        cmd  = '0;
        busy = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                busy     = 1'b0;
                cmd.load = start;
            end
            ST_SCAN:
            begin
                cmd.scan = 1'b1;
                if (sts.live_hit)
                begin
                    cmd.respond = 1'b1;
                    cmd.dup     = 1'b1;
                end
            end
            ST_INSERT:
            begin
                cmd.insert  = 1'b1;
                cmd.respond = 1'b1;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    // Accepted command always leads into the scan
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (state_reg == ST_SCAN))
        else $error("cdmf_ctrl: accepted item did not enter scan");

    // Every response returns the controller to idle
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.respond |=> !busy)
        else $error("cdmf_ctrl: still busy after response");

    // Insertion only follows a scan that ended on the last entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_INSERT) |-> ($past(sts.last_entry) && !$past(sts.live_hit)))
        else $error("cdmf_ctrl: insert without full scan");

endmodule

`default_nettype wire

// ----- hdl/cdmf_datapath.sv -----
`default_nettype none

module cdmf_datapath #(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  cdmf_pkg::cmd_t                   cmd,
    output cdmf_pkg::sts_t                   sts,
    input  wire logic [cdmf_pkg::ADDR_W-1:0] src_address,
    input  wire logic [cdmf_pkg::PORT_W-1:0] src_port,
    input  wire logic [cdmf_pkg::MID_W-1:0]  message_id,
    input  wire logic [cdmf_pkg::TIME_W-1:0] now_ms,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [cdmf_pkg::TIME_W-1:0] cfg_data,
    output logic                             done,
    output logic                             is_duplicate
);
    import cdmf_pkg::*;

    localparam int unsigned IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

    // Key, stamp and data storage
    entry_t                   entry_mem [TABLE_DEPTH];
    entry_t                   rd_data_reg;
    entry_t                   key_reg;
    entry_t                   key_next;
    logic [IDX_W-1:0]         rd_addr;

    logic [TABLE_DEPTH-1:0]   valid_reg;
    logic [TABLE_DEPTH-1:0]   valid_next;
    logic [IDX_W-1:0]         cmp_idx_reg;
    logic [IDX_W-1:0]         cmp_idx_next;
    logic [IDX_W-1:0]         ins_ptr_reg;
    logic [IDX_W-1:0]         ins_ptr_next;
    logic [TIME_W-1:0]        lifetime_reg;
    logic [TIME_W-1:0]        lifetime_next;
    logic                     done_reg;
    logic                     done_next;
    logic                     is_duplicate_reg;
    logic                     is_duplicate_next;

    logic                     key_match;
    logic [TIME_W-1:0]        age;
    logic                     hit_expired;

    // Configuration port never stalls
    assign cfg_ready = 1'b1;

    // Compare the entry read last cycle against the held key
    always_comb
    begin
        key_match = valid_reg[cmp_idx_reg]
                    && (rd_data_reg.address == key_reg.address)
                    && (rd_data_reg.port == key_reg.port)
                    && (rd_data_reg.msg_id == key_reg.msg_id);
        age = key_reg.stamp - rd_data_reg.stamp;
        sts.live_hit   = key_match && (age < lifetime_reg);
        sts.last_entry = (cmp_idx_reg == LAST_IDX);
        hit_expired    = key_match && !(age < lifetime_reg);
    end

    // Read address: entry 0 on load or at the last entry, else the entry after the current one
    always_comb
    begin
        if (cmd.load || sts.last_entry)
        begin
            rd_addr = '0;
        end
        else
        begin
            rd_addr = cmp_idx_reg + IDX_W'(1);
        end
    end

    // Table memory: write on insert, registered read
    always_ff @(posedge clk)
    begin
        if (cmd.insert)
        begin
            entry_mem[ins_ptr_reg] <= key_reg;
        end
        rd_data_reg <= entry_mem[rd_addr];
    end

    // Next values of control and payload registers
    always_comb
    begin
        key_next          = key_reg;
        valid_next        = valid_reg;
        cmp_idx_next      = cmp_idx_reg;
        ins_ptr_next      = ins_ptr_reg;
        lifetime_next     = lifetime_reg;
        done_next         = cmd.respond;
        is_duplicate_next = is_duplicate_reg;

        // Capture the key and restart the scan
        if (cmd.load)
        begin
            key_next.address = src_address;
            key_next.port    = src_port;
            key_next.msg_id  = message_id;
            key_next.stamp   = now_ms;
            cmp_idx_next     = '0;
        end

        // Drop an expired match and advance
        if (cmd.scan)
        begin
            if (hit_expired)
            begin
                valid_next[cmp_idx_reg] = 1'b0;
            end
            if (!sts.last_entry)
            begin
                cmp_idx_next = cmp_idx_reg + IDX_W'(1);
            end
        end

        // Mark the new entry live and advance the pointer
        if (cmd.insert)
        begin
            valid_next[ins_ptr_reg] = 1'b1;
            if (ins_ptr_reg == LAST_IDX)
            begin
                ins_ptr_next = '0;
            end
            else
            begin
                ins_ptr_next = ins_ptr_reg + IDX_W'(1);
            end
        end

        if (cmd.respond)
        begin
            is_duplicate_next = cmd.dup;
        end

        if (cfg_valid && cfg_ready)
        begin
            lifetime_next = cfg_data;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg        <= '0;
            cmp_idx_reg      <= '0;
            ins_ptr_reg      <= '0;
            lifetime_reg     <= LIFETIME_RESET;
            done_reg         <= 1'b0;
            is_duplicate_reg <= 1'b0;
        end
        else
        begin
            valid_reg        <= valid_next;
            cmp_idx_reg      <= cmp_idx_next;
            ins_ptr_reg      <= ins_ptr_next;
            lifetime_reg     <= lifetime_next;
            done_reg         <= done_next;
            is_duplicate_reg <= is_duplicate_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign done         = done_reg;
    assign is_duplicate = is_duplicate_reg;

    // Inserted entry is live afterwards
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.insert |=> valid_reg[$past(ins_ptr_reg)])
        else $error("cdmf_datapath: inserted entry not valid");

    // A duplicate result comes from a live hit in the previous cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_duplicate) |-> $past(sts.live_hit))
        else $error("cdmf_datapath: duplicate without live hit");

    // Pointers stay inside the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (ins_ptr_reg <= LAST_IDX) && (cmp_idx_reg <= LAST_IDX))
        else $error("cdmf_datapath: index beyond table depth");

endmodule

`default_nettype wire

// ----- hdl/coap_duplicate_message_filter.sv -----
// Duplicate filter for received CoAP messages. Pulse start with a key
// (src_address, src_port, message_id) and the current time now_ms while busy
// is low; the block scans its table of TABLE_DEPTH recent keys one entry per
// cycle out of a table memory with one write port and one registered read
// port. A live match (age below the
// lifetime register) ends the scan early with is_duplicate high;
// expired matches are dropped on the way; otherwise the key is stored at a
// round-robin pointer and is_duplicate is low. The result is shown for
// exactly one cycle with done high, and the receiver cannot stall it: done
// is registered from the scan step that finds a live hit, or from the
// insert step that follows a full scan of the table for a new key. busy
// falls in the same cycle done rises, so a new command may be issued then.
// The lifetime register (reset 247000 ms) is written through cfg_valid /
// cfg_data, which is always ready; write it only while the block is idle.
`default_nettype none

module coap_duplicate_message_filter #(
    parameter int unsigned TABLE_DEPTH = 8
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    output logic                             busy,
    input  wire logic [cdmf_pkg::ADDR_W-1:0] src_address,
    input  wire logic [cdmf_pkg::PORT_W-1:0] src_port,
    input  wire logic [cdmf_pkg::MID_W-1:0]  message_id,
    input  wire logic [cdmf_pkg::TIME_W-1:0] now_ms,
    output logic                             done,
    output logic                             is_duplicate,
    input  wire logic                        cfg_valid,
    output logic                             cfg_ready,
    input  wire logic [cdmf_pkg::TIME_W-1:0] cfg_data
);
    import cdmf_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // Scan sequencer
    cdmf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // Table, compare and result registers
    cdmf_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .sts          (sts),
        .src_address  (src_address),
        .src_port     (src_port),
        .message_id   (message_id),
        .now_ms       (now_ms),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .done         (done),
        .is_duplicate (is_duplicate)
    );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import cdmf_pkg::*;

    localparam int unsigned TABLE_DEPTH = 8;
    localparam int unsigned CYCLE_LIMIT = 300000;

    // Work the driver pulls from its queue
    typedef enum logic [1:0] {
        OP_MSG,
        OP_SET_LIFETIME,
        OP_DRAIN
    } rx_op_kind_t;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [MID_W-1:0]  mid;
    } msg_key_t;

    typedef struct {
        rx_op_kind_t       kind;
        msg_key_t          key;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] lifetime;
        int unsigned       gap;
    } rx_op_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [ADDR_W-1:0]   src_address = '0;
    logic [PORT_W-1:0]   src_port = '0;
    logic [MID_W-1:0]    message_id = '0;
    logic [TIME_W-1:0]   now_ms = '0;
    logic                done;
    logic                is_duplicate;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [TIME_W-1:0]   cfg_data = '0;

    rx_op_t              rx_queue[$];
    logic                dup_expected[$];
    int unsigned         mismatches = 0;
    int unsigned         cycles = 0;

    // Mirror of the key table and lifetime register
    entry_t              seen_entry[TABLE_DEPTH];
    logic                seen_live[TABLE_DEPTH];
    int unsigned         next_slot;
    logic [TIME_W-1:0]   lifetime_ms;

    coap_duplicate_message_filter #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .src_address  (src_address),
        .src_port     (src_port),
        .message_id   (message_id),
        .now_ms       (now_ms),
        .done         (done),
        .is_duplicate (is_duplicate),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Look a key up in the mirror table; store it when no live copy exists
    function automatic logic filter_lookup(msg_key_t k, logic [TIME_W-1:0] now);
        logic [TIME_W-1:0] age;
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            if (seen_live[i] && seen_entry[i].address == k.addr &&
                seen_entry[i].port == k.port && seen_entry[i].msg_id == k.mid)
            begin
                age = now - seen_entry[i].stamp;
                if (age < lifetime_ms)
                    return 1'b1;
                // drop the expired copy
                seen_live[i] = 1'b0;
                seen_entry[i] = '0;
            end
        end
        seen_live[next_slot] = 1'b1;
        seen_entry[next_slot].address = k.addr;
        seen_entry[next_slot].port = k.port;
        seen_entry[next_slot].msg_id = k.mid;
        seen_entry[next_slot].stamp = now;
        next_slot = (next_slot + 1) % TABLE_DEPTH;
        return 1'b0;
    endfunction

    task automatic flag_mismatch(string msg);
        $display("MISMATCH at cycle %0d: %s", cycles, msg);
        mismatches++;
    endtask

    function automatic void push_msg(logic [ADDR_W-1:0] addr, logic [PORT_W-1:0] port,
                                     logic [MID_W-1:0] mid, logic [TIME_W-1:0] now,
                                     int unsigned gap);
        rx_op_t op;
        op.kind = OP_MSG;
        op.key.addr = addr;
        op.key.port = port;
        op.key.mid = mid;
        op.now = now;
        op.lifetime = '0;
        op.gap = gap;
        rx_queue.push_back(op);
    endfunction

    function automatic void push_ctrl(rx_op_kind_t kind, logic [TIME_W-1:0] value);
        rx_op_t op;
        op.kind = kind;
        op.key.addr = '0;
        op.key.port = '0;
        op.key.mid = '0;
        op.now = '0;
        op.lifetime = value;
        op.gap = 0;
        rx_queue.push_back(op);
    endfunction

    function automatic msg_key_t fresh_key();
        msg_key_t k;
        k.addr = $urandom();
        k.port = PORT_W'($urandom_range(0, 65535));
        k.mid = MID_W'($urandom_range(0, 65535));
        return k;
    endfunction

    // Driver: one transfer at a time, config writes only once all results are in
    always @(posedge clk or negedge rst_n)
    begin : drive
        logic        nxt_start;
        logic        nxt_cfg;
        logic        quiet;
        int unsigned hold_cnt;
        rx_op_t      op;
        if (!rst_n)
        begin
            start <= 1'b0;
            cfg_valid <= 1'b0;
            hold_cnt = 0;
            next_slot = 0;
            lifetime_ms = LIFETIME_RESET;
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                seen_live[i] = 1'b0;
                seen_entry[i] = '0;
            end
        end
        else
        begin
            nxt_start = start;
            nxt_cfg = cfg_valid;
            // predict on an accepted message
            if (start && !busy)
            begin
                dup_expected.push_back(filter_lookup(
                    '{src_address, src_port, message_id}, now_ms));
                nxt_start = 1'b0;
            end
            // apply an accepted register write
            if (cfg_valid && cfg_ready)
            begin
                lifetime_ms = cfg_data;
                nxt_cfg = 1'b0;
            end
            quiet = (dup_expected.size() == 0) && !done;
            if (!nxt_start && !nxt_cfg)
            begin
                if (hold_cnt > 0)
                    hold_cnt--;
                else if (rx_queue.size() > 0)
                begin
                    op = rx_queue[0];
                    case (op.kind)
                        OP_MSG:
                        begin
                            src_address <= op.key.addr;
                            src_port <= op.key.port;
                            message_id <= op.key.mid;
                            now_ms <= op.now;
                            nxt_start = 1'b1;
                            void'(rx_queue.pop_front());
                        end
                        OP_SET_LIFETIME:
                        begin
                            if (quiet)
                            begin
                                cfg_data <= op.lifetime;
                                nxt_cfg = 1'b1;
                                void'(rx_queue.pop_front());
                            end
                        end
                        default:
                        begin
                            if (quiet)
                                void'(rx_queue.pop_front());
                        end
                    endcase
                    if (rx_queue.size() > 0 && (nxt_start || nxt_cfg))
                        hold_cnt = rx_queue[0].gap;
                end
            end
            start <= nxt_start;
            cfg_valid <= nxt_cfg;
        end
    end

    // Monitor: check each result strobe against the oldest prediction
    always @(posedge clk)
    begin : observe
        logic want;
        if (rst_n && done)
        begin
            if (dup_expected.size() == 0)
                flag_mismatch($sformatf("result with nothing pending, is_duplicate=%0b",
                                        is_duplicate));
            else
            begin
                want = dup_expected.pop_front();
                if (is_duplicate !== want)
                    flag_mismatch($sformatf("is_duplicate=%0b, predicted %0b",
                                            is_duplicate, want));
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    initial
    begin : stimulus
        msg_key_t          pool[10];
        msg_key_t          k;
        logic [TIME_W-1:0] clock_ms;
        logic [TIME_W-1:0] life;
        logic [TIME_W-1:0] step_max;
        int unsigned       gap;

        // never-written entries with an all-zero key, then its live copy
        push_msg(32'h0, 16'h0, 16'h0, 32'h0, 0);
        push_msg(32'h0, 16'h0, 16'h0, 32'h1, 0);
        // all-ones key; a later time that wraps past zero is still young
        push_msg(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 0);
        push_msg(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 32'h5, 0);
        // one field off: no match
        push_msg(32'hFFFF_FFFF, 16'hFFFF, 16'hFFFE, 32'h5, 0);
        // age one above the lifetime has expired, one below is live
        push_msg(32'h0, 16'h0, 16'h0, 32'd247001, 0);
        push_msg(32'h0, 16'h0, 16'h0, 32'd494000, 0);
        // stamp in the future: huge age, expired
        push_msg(32'h0, 16'h0, 16'h0, 32'd247000, 0);
        // zero lifetime: every match has expired
        push_ctrl(OP_SET_LIFETIME, 32'h0);
        push_msg(32'h0, 16'h0, 16'h0, 32'd247000, 0);
        push_msg(32'h0, 16'h0, 16'h0, 32'd247000, 0);
        // shortest nonzero lifetime
        push_ctrl(OP_SET_LIFETIME, 32'h1);
        push_msg(32'hA5A5_A5A5, 16'h1234, 16'h5678, 32'd100, 0);
        push_msg(32'hA5A5_A5A5, 16'h1234, 16'h5678, 32'd100, 0);
        push_msg(32'hA5A5_A5A5, 16'h1234, 16'h5678, 32'd101, 0);
        // longest lifetime
        push_ctrl(OP_SET_LIFETIME, 32'hFFFF_FFFF);
        push_msg(32'h5A5A_5A5A, 16'h8000, 16'h0001, 32'h0, 0);
        push_msg(32'h5A5A_5A5A, 16'h8000, 16'h0001, 32'hFFFF_FFFE, 0);
        push_msg(32'h5A5A_5A5A, 16'h8000, 16'h0001, 32'hFFFF_FFFF, 0);
        // overwrite: eight new keys push the last stored one out
        for (int i = 1; i <= TABLE_DEPTH; i++)
            push_msg(ADDR_W'(i), PORT_W'(i), MID_W'(i), 32'd10, 1);
        push_msg(32'h5A5A_5A5A, 16'h8000, 16'h0001, 32'h0, 0);

        // random phases, one lifetime setting each
        for (int i = 0; i < 10; i++)
            pool[i] = fresh_key();
        clock_ms = $urandom();
        for (int p = 0; p < 6; p++)
        begin
            case (p)
                0: life = $urandom_range(2, 1000);
                1: life = LIFETIME_RESET;
                2: life = 32'h1;
                3: life = 32'hFFFF_FFFF;
                4: life = $urandom();
                default: life = $urandom_range(10, 100);
            endcase
            push_ctrl(OP_SET_LIFETIME, life);
            step_max = (life / 3 > 2) ? life / 3 : 2;
            for (int n = 0; n < 100; n++)
            begin
                // mostly recent keys, some near misses and fresh ones
                if ($urandom_range(0, 3) != 0)
                begin
                    k = pool[$urandom_range(0, 9)];
                    if ($urandom_range(0, 9) == 0)
                    begin
                        case ($urandom_range(0, 2))
                            0: k.addr[$urandom_range(0, ADDR_W - 1)] ^= 1'b1;
                            1: k.port[$urandom_range(0, PORT_W - 1)] ^= 1'b1;
                            default: k.mid[$urandom_range(0, MID_W - 1)] ^= 1'b1;
                        endcase
                    end
                end
                else
                begin
                    k = fresh_key();
                    if ($urandom_range(0, 2) == 0)
                        pool[$urandom_range(0, 9)] = k;
                end
                if ($urandom_range(0, 11) == 0)
                    clock_ms = $urandom();
                else
                    clock_ms = clock_ms + $urandom_range(0, step_max);
                // bursts of idling, none in the calm phase and the last one
                if (p == 2 || p == 5)
                    gap = 0;
                else
                    gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 4) : 0;
                push_msg(k.addr, k.port, k.mid, clock_ms, gap);
                if (p != 5 && $urandom_range(0, 29) == 0)
                    push_ctrl(OP_DRAIN, '0);
            end
        end

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // wait for the last transfer and its result
        while (rx_queue.size() != 0 || start || cfg_valid || dup_expected.size() != 0)
            @(posedge clk);
        repeat (TABLE_DEPTH + 4) @(posedge clk);
        if (mismatches == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
